/* hdl/lattice_niggli_reducer_defines.svh */
// Assertion macros for the lattice reducer
`ifndef LATTICE_NIGGLI_REDUCER_DEFINES_SVH
`define LATTICE_NIGGLI_REDUCER_DEFINES_SVH
`ifndef SYNTHESIS
`define LNR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LNR_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LNR_ASSERT(label, clk, rst_n, prop, msg)
`define LNR_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* hdl/lnr_pkg.sv */
package lnr_pkg;
  localparam int WordWidthDef    = 48;
  localparam int FractionBitsDef = 16;
  localparam int SortPassesDef   = 5;
  localparam int CntW            = 10;
  localparam logic [CntW-1:0] MaxIterReset = 10'd260;
  localparam logic [15:0]     CheckTolReset = 16'd1;
  localparam logic [1:0] RegTol   = 2'd0;
  localparam logic [1:0] RegMaxIt = 2'd1;
  localparam logic [1:0] RegChk   = 2'd2;

  typedef struct packed {
    logic [31:0]     tol;
    logic [CntW-1:0] max_it;
    logic [15:0]     chk_tol;
  } lnr_cfg_t;
endpackage

/* hdl/lnr_regs.sv */
module lnr_regs
  import lnr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output lnr_cfg_t    cfg_o
);
  lnr_cfg_t cfg_q;
  logic     wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tol     <= '0;
      cfg_q.max_it  <= MaxIterReset;
      cfg_q.chk_tol <= CheckTolReset;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        RegTol:   cfg_q.tol     <= pwdata;
        RegMaxIt: cfg_q.max_it  <= pwdata[CntW-1:0];
        RegChk:   cfg_q.chk_tol <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      RegTol:   prdata = cfg_q.tol;
      RegMaxIt: prdata = {{(32-CntW){1'b0}}, cfg_q.max_it};
      RegChk:   prdata = {16'd0, cfg_q.chk_tol};
      default:  prdata = '0;
    endcase
  end
  assign cfg_o = cfg_q;
endmodule

/* hdl/lnr_core.sv */
`include "lattice_niggli_reducer_defines.svh"
module lnr_core
  import lnr_pkg::*;
#(
  parameter int WordWidth  = WordWidthDef,
  parameter int SortPasses = SortPassesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lnr_cfg_t                     cfg_i,
  input  logic                         start_i,
  input  logic signed [WordWidth-1:0]  g_i [6],
  output logic                         busy_o,
  output logic                         done_o,
  output logic signed [WordWidth-1:0]  res_o [6],
  output logic [CntW-1:0]              passes_o,
  output logic                         reduced_o,
  output logic                         limit_o
);
  localparam int W = WordWidth;
  localparam logic signed [W-1:0] VMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMin = {1'b1, {(W-1){1'b0}}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_SORT  = 4'd2;
  localparam logic [3:0] S_SIGN  = 4'd3;
  localparam logic [3:0] S_RULE  = 4'd4;
  localparam logic [3:0] S_APPLY = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMin : VMax;
    return s[W-1:0];
  endfunction
  function automatic logic signed [W-1:0] sneg(input logic signed [W-1:0] a);
    return (a == VMin) ? VMax : -a;
  endfunction
  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMin : VMax;
    return s[W-1:0];
  endfunction
  function automatic logic signed [W-1:0] sabs(input logic signed [W-1:0] a);
    return a[W-1] ? sneg(a) : a;
  endfunction

  logic [3:0]              st_q, st_d;
  logic signed [W-1:0]     g_q [6], g_d [6];
  logic signed [W-1:0]     r_q [6], r_d [6];
  logic [CntW-1:0]         pc_q, pc_d, lim;
  logic [2:0]              sc_q, sc_d;
  logic                    again_q, again_d, red_q, red_d, post_q, post_d;
  logic signed [W-1:0]     d, ct;

  assign d  = (cfg_i.tol > 32'(VMax)) ? VMax : W'(cfg_i.tol);
  assign ct = W'(cfg_i.chk_tol);
  assign lim = (cfg_i.max_it == '0) ? CntW'(1) : cfg_i.max_it;

  // reduced test over registered vector
  logic chk_ok;
  always_comb begin
    logic signed [W-1:0] s;
    logic [1:0] nn;
    s = g_q[0];
    for (int i = 1; i < 6; i++) s = sadd(s, g_q[i]);
    nn = 2'(g_q[3] <= 0) + 2'(g_q[4] <= 0) + 2'(g_q[5] <= 0);
    chk_ok = 1'b1;
    if (g_q[0] <= 0 || g_q[1] <= 0 || g_q[2] <= 0) chk_ok = 1'b0;
    if (g_q[0] > g_q[1] || g_q[1] > g_q[2]) chk_ok = 1'b0;
    if (sabs(g_q[3]) > g_q[1] || sabs(g_q[4]) > g_q[0] || sabs(g_q[5]) > g_q[0])
      chk_ok = 1'b0;
    if (nn != 2'd0 && nn != 2'd3) chk_ok = 1'b0;
    if (g_q[3] == g_q[1] && g_q[5] > sadd(g_q[4], g_q[4])) chk_ok = 1'b0;
    if (g_q[4] == g_q[0] && g_q[5] > sadd(g_q[3], g_q[3])) chk_ok = 1'b0;
    if (g_q[5] == g_q[0] && g_q[4] > sadd(g_q[3], g_q[3])) chk_ok = 1'b0;
    if (sabs(ssub(g_q[1], g_q[2])) < ct && sabs(g_q[4]) > sabs(g_q[5])) chk_ok = 1'b0;
    if (sabs(g_q[2]) > s) chk_ok = 1'b0;
    if (g_q[3] == g_q[1] && g_q[5] != 0) chk_ok = 1'b0;
    if (g_q[4] == g_q[0] && g_q[5] != 0) chk_ok = 1'b0;
    if (g_q[5] == g_q[0] && g_q[4] != 0) chk_ok = 1'b0;
    if (g_q[2] == s && sadd(sadd(g_q[0], g_q[4]), sadd(g_q[0], g_q[4])) > 0)
      chk_ok = 1'b0;
  end

  function automatic logic ordp(input logic signed [W-1:0] a, input logic signed [W-1:0] b,
                                input logic signed [W-1:0] oa, input logic signed [W-1:0] ob,
                                input logic signed [W-1:0] dd);
    if (sabs(a) > sadd(sabs(b), dd)) return 1'b1;
    return a == b && dd == 0 && sabs(oa) > sadd(sabs(ob), dd);
  endfunction

  // rule decision on the working vector
  logic [2:0] rule_sel;
  localparam logic [2:0] R_NONE = 3'd0, R_5 = 3'd1, R_6 = 3'd2, R_7 = 3'd3,
                         R_8P = 3'd4, R_8M = 3'd5;
  always_comb begin
    logic signed [W-1:0] a1, a2, t;
    a1 = sabs(g_q[0]);
    a2 = sabs(g_q[1]);
    t = sadd(sadd(sadd(sadd(g_q[3], g_q[4]), g_q[5]), a1), a2);
    if (sabs(g_q[3]) > sadd(a2, d)) rule_sel = R_5;
    else if (sabs(g_q[4]) > sadd(a1, d)) rule_sel = R_6;
    else if (sabs(g_q[5]) > sadd(a1, d)) rule_sel = R_7;
    else if (sadd(t, d) < 0) rule_sel = R_8P;
    else if ((sabs(ssub(g_q[3], g_q[1])) <= d &&
              ssub(sadd(g_q[4], g_q[4]), d) < g_q[5]) ||
             (sabs(sadd(g_q[3], g_q[1])) <= d && g_q[5] < 0)) rule_sel = R_5;
    else if ((sabs(ssub(g_q[4], g_q[0])) <= d &&
              ssub(sadd(g_q[3], g_q[3]), d) < g_q[5]) ||
             (sabs(sadd(g_q[4], g_q[0])) <= d && g_q[5] < 0)) rule_sel = R_6;
    else if ((sabs(ssub(g_q[5], g_q[0])) <= d &&
              ssub(sadd(g_q[3], g_q[3]), d) < g_q[4]) ||
             (sabs(sadd(g_q[5], g_q[0])) <= d && g_q[4] < 0)) rule_sel = R_7;
    else if (sabs(t) <= d && sadd(sadd(sadd(a1, g_q[4]), sadd(a1, g_q[4])), g_q[5]) > d)
      rule_sel = R_8M;
    else rule_sel = R_NONE;
  end

  always_comb begin
    logic [2:0] mn, zr;
    logic signed [W-1:0] s;
    logic [2:0] b, tg, of, o1, o2;
    st_d = st_q; g_d = g_q; r_d = r_q; pc_d = pc_q; sc_d = sc_q;
    again_d = again_q; red_d = red_q; post_d = post_q;
    mn = '0; zr = '0; s = '0; b = '0; tg = '0; of = '0; o1 = '0; o2 = '0;
    case (st_q)
      S_IDLE: if (start_i) begin
        g_d = g_i; st_d = S_CHK; pc_d = '0;
      end
      S_CHK: begin
        r_d = g_q; red_d = chk_ok; again_d = 1'b1; post_d = 1'b0;
        if (chk_ok) st_d = S_DONE;
        else begin st_d = S_SORT; sc_d = '0; end
      end
      S_SORT: begin
        if (sc_q >= 3'(SortPasses)) st_d = S_SIGN;
        else begin
          sc_d = sc_q + 3'd1;
          if (ordp(g_q[0], g_q[1], g_q[3], g_q[4], d)) begin
            g_d[0] = g_q[1]; g_d[1] = g_q[0]; g_d[3] = g_q[4]; g_d[4] = g_q[3];
          end else if (ordp(g_q[1], g_q[2], g_q[4], g_q[5], d)) begin
            g_d[1] = g_q[2]; g_d[2] = g_q[1]; g_d[4] = g_q[5]; g_d[5] = g_q[4];
          end else st_d = S_SIGN;
        end
      end
      S_SIGN: begin
        mn = {g_q[3] < d, g_q[4] < d, g_q[5] < d};
        zr = {sabs(g_q[3]) < d, sabs(g_q[4]) < d, sabs(g_q[5]) < d};
        case (mn)
          3'd1: begin g_d[3] = sneg(g_q[3]); g_d[4] = sneg(g_q[4]); end
          3'd2: begin g_d[3] = sneg(g_q[3]); g_d[5] = sneg(g_q[5]); end
          3'd4: begin g_d[4] = sneg(g_q[4]); g_d[5] = sneg(g_q[5]); end
          3'd3: begin
            if (zr[1]) begin g_d[3] = sneg(g_q[3]); g_d[4] = sneg(g_q[4]); end
            else if (zr[0]) begin g_d[3] = sneg(g_q[3]); g_d[5] = sneg(g_q[5]); end
            else begin g_d[4] = sneg(g_q[4]); g_d[5] = sneg(g_q[5]); end
          end
          3'd5: begin
            if (zr[2]) begin g_d[3] = sneg(g_q[3]); g_d[4] = sneg(g_q[4]); end
            else if (zr[0]) begin g_d[4] = sneg(g_q[4]); g_d[5] = sneg(g_q[5]); end
            else begin g_d[3] = sneg(g_q[3]); g_d[5] = sneg(g_q[5]); end
          end
          3'd6: begin
            if (zr[2]) begin g_d[3] = sneg(g_q[3]); g_d[5] = sneg(g_q[5]); end
            else if (zr[1]) begin g_d[4] = sneg(g_q[4]); g_d[5] = sneg(g_q[5]); end
            else begin g_d[3] = sneg(g_q[3]); g_d[4] = sneg(g_q[4]); end
          end
          default: ;
        endcase
        if (post_q) begin
          pc_d = pc_q + CntW'(1);
          if (!again_q || pc_d >= lim) st_d = S_DONE;
          else begin st_d = S_SORT; sc_d = '0; post_d = 1'b0; end
        end else st_d = S_RULE;
      end
      S_RULE: begin
        r_d = g_q;
        again_d = (rule_sel != R_NONE);
        st_d = S_APPLY;
      end
      S_APPLY: begin
        case (rule_sel)
          R_5: begin b = 3'd1; tg = 3'd2; of = 3'd3; o1 = 3'd4; o2 = 3'd5; end
          R_6: begin b = 3'd0; tg = 3'd2; of = 3'd4; o1 = 3'd3; o2 = 3'd5; end
          R_7: begin b = 3'd0; tg = 3'd1; of = 3'd5; o1 = 3'd3; o2 = 3'd4; end
          default: ;
        endcase
        case (rule_sel)
          R_5, R_6, R_7: begin
            if (g_q[of] <= 0) begin
              g_d[tg] = sadd(sadd(g_q[b], g_q[tg]), g_q[of]);
              g_d[o1] = sadd(g_q[o1], g_q[o2]);
              g_d[of] = sadd(sadd(g_q[b], g_q[b]), g_q[of]);
            end else begin
              g_d[tg] = ssub(sadd(g_q[b], g_q[tg]), g_q[of]);
              g_d[o1] = ssub(g_q[o1], g_q[o2]);
              g_d[of] = ssub(g_q[of], sadd(g_q[b], g_q[b]));
            end
          end
          R_8P, R_8M: begin
            s = g_q[0];
            for (int i = 1; i < 6; i++) s = sadd(s, g_q[i]);
            g_d[2] = s;
            if (rule_sel == R_8P) begin
              g_d[3] = sadd(sadd(sadd(g_q[1], g_q[1]), g_q[3]), g_q[5]);
              g_d[4] = sadd(sadd(sadd(g_q[0], g_q[0]), g_q[4]), g_q[5]);
            end else begin
              g_d[3] = ssub(ssub(sneg(sadd(g_q[1], g_q[1])), g_q[3]), g_q[5]);
              g_d[4] = ssub(ssub(sneg(sadd(g_q[0], g_q[0])), g_q[4]), g_q[5]);
            end
          end
          default: ;
        endcase
        r_d = g_d;
        post_d = 1'b1; sc_d = '0; st_d = S_SORT;
      end
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; pc_q <= '0; sc_q <= '0;
      again_q <= 1'b0; red_q <= 1'b0; post_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin g_q[i] <= '0; r_q[i] <= '0; end
    end else begin
      st_q <= st_d; pc_q <= pc_d; sc_q <= sc_d;
      again_q <= again_d; red_q <= red_d; post_q <= post_d;
      g_q <= g_d; r_q <= r_d;
    end
  end

  assign busy_o    = (st_q != S_IDLE);
  assign done_o    = (st_q == S_DONE);
  assign res_o     = r_q;
  assign passes_o  = red_q ? '0 : pc_q;
  assign reduced_o = red_q;
  assign limit_o   = !red_q && again_q;

  `LNR_ASSERT(a_sort_bound, clk_i, rst_ni, (st_q == S_SORT) |-> (sc_q <= 3'(SortPasses)), "sort count overran")
  `LNR_ASSERT(a_start_idle, clk_i, rst_ni, (st_q == S_IDLE && start_i) |=> (st_q == S_CHK), "start lost")
  `LNR_ASSERT(a_done_once, clk_i, rst_ni, (st_q == S_DONE) |=> (st_q == S_IDLE), "done held")
  `LNR_ASSERT(a_pass_lim, clk_i, rst_ni, done_o && !red_q |-> (pc_q <= lim), "pass limit exceeded")
endmodule

/* hdl/lattice_niggli_reducer.sv */
// Niggli reducer for one G6 vector per word.
// Input stream s_axis: one word holds g1..g6, 48-bit signed each.
// Output stream m_axis: reduced g1..g6 plus passes_used in tdata,
// already_reduced and limit_reached in tuser.
// APB port: tolerance at 0x0, max_iterations at 0x4, check_tolerance at 0x8.
// A vector that is already reduced goes from the check straight to the
// result word; otherwise each pass runs the sort, sign fix, rule pick,
// rule apply, then sort and sign fix again, for each pass used (at most
// max_iterations, or one when max_iterations is zero). One sequencer
// runs these steps.
// s_axis_tready is high only while the sequencer is idle and the output
// register is free, so one word is in flight at a time.
// If the receiver stalls, the result holds in the output register and the
// input stays stalled until that word is taken.
// Reset clears all control state and returns registers to defaults.
module lattice_niggli_reducer
  import lnr_pkg::*;
#(
  parameter int WordWidth  = WordWidthDef,
  parameter int SortPasses = SortPassesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // g1..g6 from the lowest bit up
  input  logic [6*WordWidth-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_g1..out_g6, passes_used, zero fill, from the lowest bit up
  output logic [((6*WordWidth+CntW+7)/8)*8-1:0] m_axis_tdata,
  // already_reduced, limit_reached from the lowest bit up
  output logic [1:0] m_axis_tuser,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int OW = ((6*WordWidth+CntW+7)/8)*8;
  lnr_cfg_t cfg;
  logic busy, done, red, lim;
  logic [CntW-1:0] pu;
  logic signed [WordWidth-1:0] gin [6], gres [6];
  logic ov_q;
  logic [OW-1:0] od_q;
  logic [1:0] ou_q;
  logic [6*WordWidth-1:0] flat;

  lnr_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  for (genvar i = 0; i < 6; i++) begin : g_io
    assign gin[i] = s_axis_tdata[i*WordWidth +: WordWidth];
    assign flat[i*WordWidth +: WordWidth] = gres[i];
  end

  assign s_axis_tready = !busy && !ov_q;

  lnr_core #(.WordWidth(WordWidth), .SortPasses(SortPasses)) u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .start_i(s_axis_tvalid && s_axis_tready),
    .g_i(gin), .busy_o(busy), .done_o(done), .res_o(gres), .passes_o(pu),
    .reduced_o(red), .limit_o(lim)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (done) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (done) begin
      od_q <= OW'({pu, flat});
      ou_q <= {lim, red};
    end
  end
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
endmodule
